// File: rtl/mlfe_pkg.sv
// Shared types and constants of the multichannel linear fade engine.
package mlfe_pkg;

	localparam int LVL_W  = 12;
	localparam int DUR_W  = 24;
	localparam int TIME_W = 32;
	localparam int PCT_W  = 7;
	localparam int CHN_W  = 8;
	localparam int OCH_W  = 6;

	localparam logic [PCT_W-1:0]  PCT_MAX     = 7'd100;
	localparam logic [DUR_W-1:0]  DEFAULT_DUR = 24'd1000;
	localparam logic [DUR_W-1:0]  MIN_DUR     = 24'd1;
	localparam logic [18:0]       ROUND_HALF  = 19'd50;
	// x / 100 == (x * RECIP_100) >> RECIP_SHIFT, exact for x below 2^19
	localparam logic [19:0]       RECIP_100   = 20'd671089;
	localparam int                RECIP_SHIFT = 26;

	localparam logic OP_SET  = 1'b0;
	localparam logic OP_TICK = 1'b1;

	typedef struct packed {
		logic [LVL_W-1:0]  start_lvl;
		logic [LVL_W-1:0]  cur_lvl;
		logic [LVL_W-1:0]  tgt_lvl;
		logic [TIME_W-1:0] start_time;
		logic [DUR_W-1:0]  dur;
	} fade_entry_t;

	localparam fade_entry_t ENTRY_RESET = '{
		start_lvl:  '0,
		cur_lvl:    '0,
		tgt_lvl:    '0,
		start_time: '0,
		dur:        DEFAULT_DUR
	};

endpackage

// File: rtl/multichannel_linear_fade_engine.sv
// Multichannel linear fade engine: per-channel fade table and tick sequencer.
//
// Usage: one input stream (s_axis_*) carries requests. tuser selects the kind:
// a set request latches a new fade for channel 1..NUM_CHANNELS (others are
// dropped); a tick request carries the millisecond time and makes the block
// walk every channel, interpolating start->target over the fade duration.
// Every channel whose level changes produces one result on m_axis_*, in
// ascending channel order; tlast marks the final result of the tick. A tick
// with no change produces nothing.
// Sequence: a set reads the channel entry, then writes the new fade. A tick
// reads and evaluates each channel in turn: one at rest is skipped, a snap
// writes the target, and one that needs the division runs a 24x12 multiply,
// then a restoring divider, one quotient bit a cycle; the held result is
// flushed at the end. s_axis_tready low while busy.
// Results pass through a one-deep holding slot (needed to know which one is
// last) and an output register; when the receiver stalls, the channel walk
// waits at the next change until the output register frees up.
// Reset (arst_n low) clears all channel valid bits, so every channel reads as
// level 0, target 0, start time 0, duration 1000 ms; nothing is pending.
module multichannel_linear_fade_engine #(
	parameter int NUM_CHANNELS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// [7:0] channel, [14:8] brightness, [38:15] fade_ms, [70:39] now_ms, [71] zero
	input  logic [71:0] s_axis_tdata,
	// [0] operation
	input  logic        s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [5:0] out_channel, [17:6] level, [23:18] zero
	output logic [23:0] m_axis_tdata,
	output logic        m_axis_tlast
);
	import mlfe_pkg::*;

	localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam logic [CH_W-1:0] LAST_IDX = CH_W'(NUM_CHANNELS - 1);
	localparam logic [CHN_W-1:0] NUM_CH8 = CHN_W'(NUM_CHANNELS);

	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_SET_RD = 4'd1;
	localparam logic [3:0] ST_SET_WR = 4'd2;
	localparam logic [3:0] ST_T_RD   = 4'd3;
	localparam logic [3:0] ST_T_EVAL = 4'd4;
	localparam logic [3:0] ST_T_MUL  = 4'd5;
	localparam logic [3:0] ST_T_DIV  = 4'd6;
	localparam logic [3:0] ST_T_UPD  = 4'd7;
	localparam logic [3:0] ST_T_EMIT = 4'd8;
	localparam logic [3:0] ST_FLUSH  = 4'd9;

	// request fields
	logic [CHN_W-1:0]  in_ch;
	logic [PCT_W-1:0]  in_pct;
	logic [DUR_W-1:0]  in_fade;
	logic [TIME_W-1:0] in_now;
	assign in_ch   = s_axis_tdata[7:0];
	assign in_pct  = s_axis_tdata[14:8];
	assign in_fade = s_axis_tdata[38:15];
	assign in_now  = s_axis_tdata[70:39];

	logic [3:0]        state_q;
	logic [CH_W-1:0]   idx_q;
	logic [PCT_W-1:0]  pct_q;
	logic [DUR_W-1:0]  fade_q;
	logic [TIME_W-1:0] now_q;
	logic [LVL_W-1:0]  tgt_q;

	// channel table: memory plus per-entry valid bits
	fade_entry_t               mem [NUM_CHANNELS];
	logic [NUM_CHANNELS-1:0]   vld_q;
	fade_entry_t               rd_q;
	logic                      rd_vld_q;
	fade_entry_t               ent;
	fade_entry_t               ent_q;
	logic                      wr_en;
	fade_entry_t               wr_data;

	// interpolation datapath
	logic [DUR_W-1:0]  el_q;
	logic [LVL_W-1:0]  diff_q;
	logic              neg_q;
	logic [DUR_W-1:0]  rem_q;
	logic [LVL_W-1:0]  numlo_q;
	logic [LVL_W-1:0]  quo_q;
	logic [3:0]        cnt_q;
	logic [LVL_W-1:0]  nl_q;

	// result holding slot and output register
	logic              pend_v_q;
	logic [CH_W-1:0]   pend_ch_q;
	logic [LVL_W-1:0]  pend_lvl_q;
	logic              out_v_q;
	logic [OCH_W-1:0]  out_ch_q;
	logic [LVL_W-1:0]  out_lvl_q;
	logic              out_last_q;
	logic              out_free;
	logic              out_load;

	logic [TIME_W-1:0] elapsed;
	logic [35:0]       prod;
	logic [35:0]       num;
	logic [DUR_W:0]    trial;
	logic [DUR_W:0]    dur_ext;
	logic              trial_ge;
	logic [PCT_W-1:0]  pct_sat;
	logic [18:0]       scaled;
	logic [38:0]       recip_prod;
	logic              last_ch;
	logic              s_acc;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign s_acc         = s_axis_tvalid && s_axis_tready;
	assign out_free      = !out_v_q || m_axis_tready;
	// output register takes a held result this cycle
	assign out_load      = out_free && ((state_q == ST_T_EMIT) ||
	                                    (state_q == ST_FLUSH && pend_v_q));
	assign last_ch       = (idx_q == LAST_IDX);

	assign ent      = rd_vld_q ? rd_q : ENTRY_RESET;
	assign elapsed  = now_q - ent.start_time;
	assign prod     = 36'(el_q) * 36'(diff_q);
	assign num      = neg_q ? prod + 36'(ent_q.dur - MIN_DUR) : prod;
	assign trial    = {rem_q, numlo_q[LVL_W-1]};
	assign dur_ext  = {1'b0, ent_q.dur};
	assign trial_ge = (trial >= dur_ext);

	// target = round(pct * 4095 / 100); pct*4095 as (pct<<12) - pct
	assign pct_sat    = (pct_q > PCT_MAX) ? PCT_MAX : pct_q;
	assign scaled     = ({pct_sat, 12'd0} - 19'(pct_sat)) + ROUND_HALF;
	assign recip_prod = 39'(scaled) * 39'(RECIP_100);

	always_comb begin
		wr_en   = 1'b0;
		wr_data = ent_q;
		unique case (state_q)
			ST_SET_WR: begin
				wr_en              = 1'b1;
				wr_data.start_lvl  = ent.cur_lvl;
				wr_data.cur_lvl    = ent.cur_lvl;
				wr_data.tgt_lvl    = tgt_q;
				wr_data.start_time = now_q;
				wr_data.dur        = (fade_q == '0) ? MIN_DUR : fade_q;
			end
			ST_T_UPD: begin
				wr_en           = (nl_q != ent_q.cur_lvl);
				wr_data.cur_lvl = nl_q;
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[idx_q] <= wr_data;
		end
		rd_q <= mem[idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[idx_q] <= 1'b1;
			end
			rd_vld_q <= vld_q[idx_q];
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (s_acc) begin
			pct_q  <= in_pct;
			fade_q <= in_fade;
			now_q  <= in_now;
		end
		unique case (state_q)
			ST_SET_RD: begin
				tgt_q <= recip_prod[RECIP_SHIFT +: LVL_W];
			end
			ST_T_EVAL: begin
				ent_q  <= ent;
				el_q   <= elapsed[DUR_W-1:0];
				neg_q  <= (ent.tgt_lvl < ent.start_lvl);
				diff_q <= (ent.tgt_lvl < ent.start_lvl) ? ent.start_lvl - ent.tgt_lvl
				                                        : ent.tgt_lvl - ent.start_lvl;
				nl_q   <= ent.tgt_lvl;
			end
			ST_T_MUL: begin
				rem_q   <= num[35:LVL_W];
				numlo_q <= num[LVL_W-1:0];
				quo_q   <= '0;
			end
			ST_T_DIV: begin
				rem_q   <= trial_ge ? DUR_W'(trial - dur_ext) : trial[DUR_W-1:0];
				numlo_q <= {numlo_q[LVL_W-2:0], 1'b0};
				quo_q   <= {quo_q[LVL_W-2:0], trial_ge};
				if (cnt_q == 4'd0) begin
					nl_q <= neg_q ? ent_q.start_lvl - {quo_q[LVL_W-2:0], trial_ge}
					              : ent_q.start_lvl + {quo_q[LVL_W-2:0], trial_ge};
				end
			end
			default: begin
			end
		endcase
	end

	// sequencer, holding slot and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			idx_q      <= '0;
			cnt_q      <= '0;
			pend_v_q   <= 1'b0;
			pend_ch_q  <= '0;
			pend_lvl_q <= '0;
			out_v_q    <= 1'b0;
			out_ch_q   <= '0;
			out_lvl_q  <= '0;
			out_last_q <= 1'b0;
		end else begin
			if (out_v_q && m_axis_tready && !out_load) begin
				out_v_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_acc) begin
						if (s_axis_tuser == OP_TICK) begin
							idx_q   <= '0;
							state_q <= ST_T_RD;
						end else if (in_ch != '0 && in_ch <= NUM_CH8) begin
							idx_q   <= CH_W'(in_ch - 8'd1);
							state_q <= ST_SET_RD;
						end
					end
				end
				ST_SET_RD: state_q <= ST_SET_WR;
				ST_SET_WR: state_q <= ST_IDLE;
				ST_T_RD:   state_q <= ST_T_EVAL;
				ST_T_EVAL: begin
					if (ent.cur_lvl == ent.tgt_lvl) begin
						idx_q   <= last_ch ? idx_q : idx_q + CH_W'(1);
						state_q <= last_ch ? ST_FLUSH : ST_T_RD;
					end else if (elapsed >= TIME_W'(ent.dur)) begin
						state_q <= ST_T_UPD;
					end else begin
						state_q <= ST_T_MUL;
					end
				end
				ST_T_MUL: begin
					cnt_q   <= 4'(LVL_W - 1);
					state_q <= ST_T_DIV;
				end
				ST_T_DIV: begin
					cnt_q <= cnt_q - 4'd1;
					if (cnt_q == 4'd0) begin
						state_q <= ST_T_UPD;
					end
				end
				ST_T_UPD: begin
					if (nl_q != ent_q.cur_lvl && pend_v_q) begin
						state_q <= ST_T_EMIT;
					end else begin
						if (nl_q != ent_q.cur_lvl) begin
							pend_v_q   <= 1'b1;
							pend_ch_q  <= idx_q;
							pend_lvl_q <= nl_q;
						end
						idx_q   <= last_ch ? idx_q : idx_q + CH_W'(1);
						state_q <= last_ch ? ST_FLUSH : ST_T_RD;
					end
				end
				ST_T_EMIT: begin
					if (out_free) begin
						out_v_q    <= 1'b1;
						out_ch_q   <= OCH_W'(pend_ch_q);
						out_lvl_q  <= pend_lvl_q;
						out_last_q <= 1'b0;
						pend_ch_q  <= idx_q;
						pend_lvl_q <= nl_q;
						idx_q      <= last_ch ? idx_q : idx_q + CH_W'(1);
						state_q    <= last_ch ? ST_FLUSH : ST_T_RD;
					end
				end
				ST_FLUSH: begin
					if (!pend_v_q) begin
						state_q <= ST_IDLE;
					end else if (out_free) begin
						out_v_q    <= 1'b1;
						out_ch_q   <= OCH_W'(pend_ch_q);
						out_lvl_q  <= pend_lvl_q;
						out_last_q <= 1'b1;
						pend_v_q   <= 1'b0;
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = {6'd0, out_lvl_q, out_ch_q};
	assign m_axis_tlast  = out_last_q;

	// no result may stay in the holding slot once the block is idle
	a_idle_no_pend: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready |-> !pend_v_q)
		else $error("result left in holding slot while idle");

	// restoring divider: partial remainder always below the divisor
	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_T_DIV) |-> (rem_q < ent_q.dur))
		else $error("divider remainder out of range");

	// a second change can only wait to emit behind a held result
	a_emit_pend: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_T_EMIT) |-> pend_v_q)
		else $error("emit without held result");

endmodule
